// File: hw/rtl/mbq_pkg.sv
// Package: shared types and constants for the multivoice biquad cascade.
package mbq_pkg;

    localparam int COEF_W = 32;
    localparam int SIG_W = 32;
    localparam int SAMPLE_W = 24;
    localparam int NCOEF = 5;
    localparam logic signed [SAMPLE_W-1:0] OUT_LIMIT = 24'sd6291456;
    localparam logic [15:0] WET_MIX_RESET = 16'd32768;
    localparam logic [16:0] OUT_LEVEL_RESET = 17'd32768;
    localparam logic signed [COEF_W-1:0] ONE_Q23 = 32'sd8388608;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [2:0] SEL_B0 = 3'd0;
    localparam logic [2:0] SEL_B1 = 3'd1;
    localparam logic [2:0] SEL_B2 = 3'd2;
    localparam logic [2:0] SEL_A1 = 3'd3;
    localparam logic [2:0] SEL_A2 = 3'd4;

    localparam logic REG_WET_MIX = 1'b0;
    localparam logic REG_OUT_LEVEL = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [3:0]                 voice;
        logic [2:0]                 section;
        logic [2:0]                 coef_select;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]                 out_voice;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       voice_cleared;
    } out_beat_t;

endpackage

// File: hw/rtl/mbq_front.sv
// Front end: accepts beats, drops bad addresses and queues valid commands.
module mbq_front #(
    parameter int VOICES = 16,
    parameter int SECTIONS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mbq_pkg::in_beat_t in_data,
    output logic              q_valid,
    input  logic              q_ready,
    output mbq_pkg::in_beat_t q_data
);

    localparam int DEPTH = 2;

    mbq_pkg::in_beat_t fifo_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       keep;
    logic       push, pop;

    always_comb
    begin
        if (in_data.action == mbq_pkg::ACT_LOAD)
            keep = (32'(in_data.voice) < VOICES) && (32'(in_data.section) < SECTIONS)
                   && (in_data.coef_select <= mbq_pkg::SEL_A2);
        else
            keep = 32'(in_data.voice) < VOICES;
    end

    assign in_ready = (count_reg != 2'(DEPTH));
    assign push = in_valid && in_ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: hw/rtl/mbq_back.sv
// Back end: sequencer running the biquad cascade on one shared multiplier, then the mix and level.
module mbq_back #(
    parameter int VOICES = 16,
    parameter int SECTIONS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  mbq_pkg::in_beat_t  q_data,
    input  logic [15:0]        wet_mix,
    input  logic [16:0]        out_level,
    output logic               out_valid,
    input  logic               out_ready,
    output mbq_pkg::out_beat_t out_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CDEPTH = VOICES * SECTIONS * mbq_pkg::NCOEF;
    localparam int DDEPTH = VOICES * SECTIONS * 2;
    localparam int CAW = $clog2(CDEPTH);
    localparam int DAW = $clog2(DDEPTH);
    localparam int CLR_W = $clog2(CDEPTH + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_P0, S_P1, S_P3, S_P2, S_P4,
        S_WB, S_ZCLR, S_MIX, S_LVL, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [mbq_pkg::COEF_W-1:0] coef_mem [CDEPTH];
    logic signed [mbq_pkg::SIG_W-1:0]  delay_mem [DDEPTH];
    logic signed [mbq_pkg::COEF_W-1:0] coef_rd_reg;
    logic signed [mbq_pkg::SIG_W-1:0]  delay_rd_reg;

    logic [CLR_W-1:0] clr_reg;
    logic [2:0]       clr_mod_reg;
    logic [VW-1:0]    voice_reg;
    logic [SW-1:0]    sec_reg;
    logic [2:0]       step_reg;
    logic signed [23:0] dry_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [43:0] acc1_reg, acc2_reg, z1_reg;
    logic             cleared_reg;
    logic signed [47:0] t_reg;
    logic             ov_valid_reg;
    mbq_pkg::out_beat_t ov_reg;
    logic             ov_load;

    // shared multiplier operands
    logic signed [mbq_pkg::COEF_W-1:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [65:0] prod;
    logic signed [42:0] rnd;
    logic [CAW-1:0] c_addr;
    logic [DAW-1:0] d_addr;
    logic [CAW-1:0] base_c;
    logic [DAW-1:0] base_d;
    logic c_we, d_we;
    logic [CAW-1:0] c_waddr;
    logic [DAW-1:0] d_waddr;
    logic signed [31:0] c_wdata, d_wdata;
    logic signed [43:0] y_sum;
    logic signed [15:0] m_eff;
    logic signed [17:0] g_eff;
    logic signed [47:0] mix_sum;
    logic signed [32:0] t_rnd;
    logic signed [51:0] lvl;
    logic signed [36:0] u_rnd;
    logic signed [23:0] u_clip;

    function automatic logic ovf(input logic signed [43:0] v);
        ovf = (v > 44'sd2147483647) || (v < -44'sd2147483648);
    endfunction

    assign base_c = CAW'((32'(voice_reg) * SECTIONS + 32'(sec_reg)) * mbq_pkg::NCOEF);
    assign base_d = DAW'((32'(voice_reg) * SECTIONS + 32'(sec_reg)) * 2);

    // read address sequencing: coef read one state ahead
    always_comb
    begin
        c_addr = base_c;
        d_addr = base_d;
        unique case (state_reg)
            S_RD:    c_addr = base_c;
            S_P0:    begin c_addr = base_c + CAW'(mbq_pkg::SEL_B1); d_addr = base_d + DAW'(1); end
            S_P1:    c_addr = base_c + CAW'(mbq_pkg::SEL_A1);
            S_P3:    c_addr = base_c + CAW'(mbq_pkg::SEL_B2);
            S_P2:    c_addr = base_c + CAW'(mbq_pkg::SEL_A2);
            default: c_addr = base_c;
        endcase
    end

    always_comb
    begin
        mul_a = coef_rd_reg;
        mul_b = x_reg;
        if (state_reg == S_P3 || state_reg == S_P4)
            mul_b = y_reg;
        prod = 66'(mul_a) * 66'(mul_b);
        rnd = 43'((prod + 66'sd4194304) >>> 23);
        y_sum = 44'(rnd) + 44'(delay_rd_reg);
    end

    always_comb
    begin
        m_eff = (wet_mix > 16'd32768) ? 16'sd32767 + 16'sd1 : $signed(wet_mix);
        g_eff = (out_level > 17'd65536) ? 18'sd65536 : $signed({1'b0, out_level});
        mix_sum = 48'(dry_reg) * 48'(17'sd32768 - 17'($unsigned(m_eff)))
                  + 48'(cleared_reg ? 34'sd0 : x_reg) * 48'($unsigned(m_eff));
        t_rnd = 33'((mix_sum + 48'sd16384) >>> 15);
        lvl = 52'(t_reg) * 52'(g_eff);
        u_rnd = 37'((lvl + 52'sd16384) >>> 15);
        if (u_rnd > 37'(mbq_pkg::OUT_LIMIT))
            u_clip = mbq_pkg::OUT_LIMIT;
        else if (u_rnd < -37'(mbq_pkg::OUT_LIMIT))
            u_clip = -mbq_pkg::OUT_LIMIT;
        else
            u_clip = 24'(u_rnd);
    end

    // store write ports
    always_comb
    begin
        c_we = 1'b0;
        c_waddr = CAW'(clr_reg);
        c_wdata = (clr_mod_reg == mbq_pkg::SEL_B0) ? mbq_pkg::ONE_Q23 : 32'sd0;
        d_we = 1'b0;
        d_waddr = DAW'(clr_reg);
        d_wdata = 32'sd0;
        if (state_reg == S_CLEAR)
        begin
            c_we = 1'b1;
            d_we = (32'(clr_reg) < DDEPTH);
        end
        else if (state_reg == S_IDLE && q_valid && q_data.action == mbq_pkg::ACT_LOAD)
        begin
            c_we = 1'b1;
            c_waddr = CAW'((32'(q_data.voice) * SECTIONS + 32'(q_data.section))
                           * mbq_pkg::NCOEF + 32'(q_data.coef_select));
            c_wdata = q_data.coef_value;
        end
        else if (state_reg == S_WB)
        begin
            d_we = 1'b1;
            d_waddr = base_d + DAW'(step_reg[0]);
            d_wdata = step_reg[0] ? 32'(acc2_reg) : 32'(z1_reg);
        end
        else if (state_reg == S_ZCLR)
        begin
            d_we = 1'b1;
            d_waddr = DAW'((32'(voice_reg) * SECTIONS + 32'(sec_reg)) * 2 + 32'(step_reg[0]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            coef_mem[c_waddr] <= c_wdata;
        if (d_we)
            delay_mem[d_waddr] <= d_wdata;
        coef_rd_reg <= coef_mem[c_addr];
        delay_rd_reg <= delay_mem[d_addr];
    end

    assign q_ready = (state_reg == S_IDLE);
    assign out_valid = ov_valid_reg;
    assign out_data = ov_reg;
    assign ov_load = (state_reg == S_LVL) && (!ov_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            clr_mod_reg <= '0;
            ov_valid_reg <= 1'b0;
            voice_reg <= '0;
            sec_reg <= '0;
            step_reg <= '0;
            cleared_reg <= 1'b0;
        end
        else
        begin
            if (ov_load)
                ov_valid_reg <= 1'b1;
            else if (out_valid && out_ready)
                ov_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    clr_mod_reg <= (clr_mod_reg == 3'(mbq_pkg::NCOEF - 1)) ? 3'd0
                                   : clr_mod_reg + 3'd1;
                    if (32'(clr_reg) == CDEPTH - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_valid && q_data.action == mbq_pkg::ACT_SAMPLE)
                    begin
                        voice_reg <= VW'(q_data.voice);
                        sec_reg <= '0;
                        dry_reg <= q_data.sample_in;
                        x_reg <= 34'(q_data.sample_in);
                        cleared_reg <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_P0;
                S_P0:
                begin
                    y_reg <= 34'(y_sum);
                    if (ovf(y_sum))
                    begin
                        cleared_reg <= 1'b1;
                        sec_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_ZCLR;
                    end
                    else
                        state_reg <= S_P1;
                end
                S_P1:
                begin
                    acc1_reg <= 44'(rnd) + 44'(delay_rd_reg);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    z1_reg <= acc1_reg - 44'(rnd);
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    acc2_reg <= 44'(rnd);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    acc2_reg <= acc2_reg - 44'(rnd);
                    if (ovf(z1_reg) || ovf(acc2_reg - 44'(rnd)))
                    begin
                        cleared_reg <= 1'b1;
                        sec_reg <= '0;
                        step_reg <= '0;
                        state_reg <= S_ZCLR;
                    end
                    else
                    begin
                        step_reg <= '0;
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg[0])
                    begin
                        x_reg <= y_reg;
                        if (32'(sec_reg) == SECTIONS - 1)
                            state_reg <= S_MIX;
                        else
                        begin
                            sec_reg <= sec_reg + SW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_ZCLR:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg[0])
                    begin
                        if (32'(sec_reg) == SECTIONS - 1)
                            state_reg <= S_MIX;
                        else
                            sec_reg <= sec_reg + SW'(1);
                    end
                end
                S_MIX:
                begin
                    t_reg <= 48'(t_rnd);
                    state_reg <= S_LVL;
                end
                S_LVL:
                begin
                    if (ov_load)
                    begin
                        ov_reg.out_voice <= 4'(voice_reg);
                        ov_reg.sample_out <= u_clip;
                        ov_reg.voice_cleared <= cleared_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/mbq_regs.sv
// APB register block holding wet_mix and out_level.
module mbq_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] wet_mix,
    output logic [16:0] out_level
);

    logic [15:0] wet_mix_reg;
    logic [16:0] out_level_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign wet_mix = wet_mix_reg;
    assign out_level = out_level_reg;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mbq_pkg::REG_WET_MIX)
            prdata = {16'd0, wet_mix_reg};
        else
            prdata = {15'd0, out_level_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_mix_reg <= mbq_pkg::WET_MIX_RESET;
            out_level_reg <= mbq_pkg::OUT_LEVEL_RESET;
        end
        else if (wr && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == mbq_pkg::REG_WET_MIX)
                wet_mix_reg <= pwdata[15:0];
            else
                out_level_reg <= pwdata[16:0];
        end
    end

endmodule

// File: hw/rtl/multivoice_biquad_cascade.sv
// Top level of the multivoice biquad cascade.
// Each sample beat runs through SECTIONS biquads (TDF-II) on one shared 32x34 multiplier:
// per section a coefficient store read, five products and a delay write-back pair; the
// accept comes before the sections, the mix and level after them, and beats pass first
// through the registered front queue. On overflow the remaining sections are skipped and
// the voice's delays are zeroed in every section. After reset a clearing pass over the
// VOICES*SECTIONS*5 coefficient words (480) presets the stores; the front queue takes
// at most two beats during it.
module multivoice_biquad_cascade #(
    parameter int VOICES = 16,
    parameter int SECTIONS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mbq_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mbq_pkg::out_beat_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic              q_valid, q_ready;
    mbq_pkg::in_beat_t q_data;
    logic [15:0]       wet_mix;
    logic [16:0]       out_level;

    mbq_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .wet_mix(wet_mix), .out_level(out_level)
    );

    mbq_front #(.VOICES(VOICES), .SECTIONS(SECTIONS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    mbq_back #(.VOICES(VOICES), .SECTIONS(SECTIONS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .wet_mix(wet_mix), .out_level(out_level), .out_valid(out_valid),
        .out_ready(out_ready), .out_data(out_data)
    );

endmodule

// File: hw/rtl/mbq_checker.sv
// Port-level checker for the multivoice biquad cascade, bound to the top level.
module mbq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input mbq_pkg::out_beat_t out_data,
    input logic               pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sample_out <= mbq_pkg::OUT_LIMIT)
                   && (out_data.sample_out >= -mbq_pkg::OUT_LIMIT))
        else $error("sample_out beyond clamp");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind multivoice_biquad_cascade mbq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .pready(pready)
);

// File: sim/mbq_checker.sv
// Checker: predicts cascade output beats from accepted input beats and compares.
module mbq_scoreboard #(
    parameter int VOICES = 16,
    parameter int SECTIONS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  mbq_pkg::in_beat_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  mbq_pkg::out_beat_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    logic signed [63:0] coefs [VOICES*SECTIONS*mbq_pkg::NCOEF];
    logic signed [63:0] delays [VOICES*SECTIONS*2];
    logic [15:0] mix_reg;
    logic [16:0] level_reg;
    mbq_pkg::out_beat_t expected_q[$];

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic ovf(input logic signed [63:0] v);
        return v < -(64'sd1 <<< 31) || v > (64'sd1 <<< 31) - 1;
    endfunction

    task automatic run_sample(input mbq_pkg::in_beat_t b);
        logic signed [63:0] dry, x, y, n1, n2, t, u, m, g;
        logic cleared;
        int base;
        mbq_pkg::out_beat_t r;
        cleared = 0;
        dry = b.sample_in;
        x = dry;
        for (int s = 0; s < SECTIONS; s++)
        begin
            base = b.voice * SECTIONS + s;
            y = rnd(coefs[base*mbq_pkg::NCOEF+mbq_pkg::SEL_B0] * x, 23) + delays[base*2];
            if (ovf(y))
            begin
                cleared = 1;
                break;
            end
            n1 = rnd(coefs[base*mbq_pkg::NCOEF+mbq_pkg::SEL_B1] * x, 23)
                - rnd(coefs[base*mbq_pkg::NCOEF+mbq_pkg::SEL_A1] * y, 23)
                + delays[base*2+1];
            n2 = rnd(coefs[base*mbq_pkg::NCOEF+mbq_pkg::SEL_B2] * x, 23)
                - rnd(coefs[base*mbq_pkg::NCOEF+mbq_pkg::SEL_A2] * y, 23);
            if (ovf(n1) || ovf(n2))
            begin
                cleared = 1;
                break;
            end
            delays[base*2] = n1;
            delays[base*2+1] = n2;
            x = y;
        end
        if (cleared)
        begin
            for (int s = 0; s < SECTIONS; s++)
            begin
                delays[(b.voice*SECTIONS+s)*2] = 0;
                delays[(b.voice*SECTIONS+s)*2+1] = 0;
            end
            x = 0;
        end
        m = mix_reg > 32768 ? 32768 : mix_reg;
        g = level_reg > 65536 ? 65536 : level_reg;
        t = rnd(dry * (32768 - m) + x * m, 15);
        u = rnd(t * g, 15);
        if (u > 6291456) u = 6291456;
        if (u < -6291456) u = -6291456;
        r.out_voice = b.voice;
        r.sample_out = u[23:0];
        r.voice_cleared = cleared;
        expected_q = {expected_q, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mbq_pkg::out_beat_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES*SECTIONS; i++)
            begin
                for (int k = 0; k < mbq_pkg::NCOEF; k++)
                    coefs[i*mbq_pkg::NCOEF+k] = (k == mbq_pkg::SEL_B0) ? mbq_pkg::ONE_Q23 : 0;
                delays[i*2] = 0;
                delays[i*2+1] = 0;
            end
            mix_reg <= mbq_pkg::WET_MIX_RESET;
            level_reg <= mbq_pkg::OUT_LEVEL_RESET;
            errors <= 0;
            pending <= 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {mbq_pkg::REG_WET_MIX, 2'b00}) mix_reg <= pwdata[15:0];
                else if (paddr == {mbq_pkg::REG_OUT_LEVEL, 2'b00}) level_reg <= pwdata[16:0];
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10) $display("unexpected output beat %p", out_data);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e !== out_data)
                    begin
                        errors <= errors + 1;
                        if (errors < 10) $display("mismatch: expected %p got %p", e, out_data);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.action == mbq_pkg::ACT_LOAD)
                begin
                    if (in_data.voice < VOICES && in_data.section < SECTIONS
                        && in_data.coef_select < mbq_pkg::NCOEF)
                        coefs[(in_data.voice*SECTIONS+in_data.section)*mbq_pkg::NCOEF
                            + in_data.coef_select] = in_data.coef_value;
                end
                else if (in_data.voice < VOICES)
                begin
                    run_sample(in_data);
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

// File: sim/tb_multivoice_biquad_cascade.sv
// Testbench top: stimulus, configuration phases and verdict for the biquad cascade.
module tb_multivoice_biquad_cascade;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    mbq_pkg::in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    mbq_pkg::out_beat_t out_data;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    int errors, pending;
    logic calm = 0;
    logic hold_off = 0;
    logic [31:0] mixes [5] = '{32768, 0, 16384, 65535, 24000};
    logic [31:0] levels [5] = '{32768, 65536, 0, 131071, 50000};

    always #5 clk = ~clk;

    multivoice_biquad_cascade dut (.*);

    mbq_scoreboard chk (.*);

    always @(posedge clk)
    begin
        int gap;
        if (hold_off)
        begin
            out_ready <= 0;
            repeat (400) @(posedge clk);
            hold_off = 0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            out_ready <= 0;
            repeat (gap) @(posedge clk);
        end
        out_ready <= 1;
    end

    task automatic apb_write(input logic idx, input logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send_beat(input mbq_pkg::in_beat_t b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic mbq_pkg::in_beat_t load_beat(input int v, input int s, input int c,
                                                    input logic [31:0] val);
        mbq_pkg::in_beat_t b;
        b = '0;
        b.action = mbq_pkg::ACT_LOAD;
        b.voice = 4'(v);
        b.section = 3'(s);
        b.coef_select = 3'(c);
        b.coef_value = val;
        b.sample_in = 24'($urandom);
        return b;
    endfunction

    function automatic mbq_pkg::in_beat_t sample_beat(input int v, input logic [23:0] x);
        mbq_pkg::in_beat_t b;
        b = '0;
        b.action = mbq_pkg::ACT_SAMPLE;
        b.voice = 4'(v);
        b.section = 3'($urandom);
        b.coef_select = 3'($urandom);
        b.coef_value = $urandom;
        b.sample_in = x;
        return b;
    endfunction

    function automatic logic [31:0] stable_coef(input int c);
        case (c)
            mbq_pkg::SEL_B0: return 32'($urandom_range(0, 2 * 8388608) - 8388608);
            mbq_pkg::SEL_A1: return 32'($urandom_range(0, 8388608) - 4194304);
            mbq_pkg::SEL_A2: return 32'($urandom_range(0, 4194304));
            default: return 32'($urandom_range(0, 4194304) - 2097152);
        endcase
    endfunction

    function automatic mbq_pkg::in_beat_t random_beat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return sample_beat($urandom_range(0, 15), 24'($urandom));
        if (r < 85) return load_beat($urandom_range(0, 15), $urandom_range(0, 5),
                                     $urandom_range(0, 4), 0);
        if (r < 95) return load_beat($urandom, $urandom, $urandom, $urandom);
        return sample_beat($urandom_range(0, 15), $urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
    endfunction

    initial
    begin
        mbq_pkg::in_beat_t b;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed
        send_beat(sample_beat(0, 24'h7fffff));
        send_beat(sample_beat(15, 24'h800000));
        send_beat(sample_beat(3, 24'h000000));
        send_beat(load_beat(2, 0, mbq_pkg::SEL_B0, 32'h7fffffff));
        send_beat(load_beat(2, 1, mbq_pkg::SEL_B0, 32'h7fffffff));
        send_beat(sample_beat(2, 24'h7fffff));
        send_beat(sample_beat(2, 24'h7fffff));
        send_beat(load_beat(2, 0, mbq_pkg::SEL_B0, 32'h80000000));
        send_beat(sample_beat(2, 24'h800000));
        send_beat(load_beat(1, 5, mbq_pkg::SEL_A2, 32'h00400000));
        send_beat(load_beat(1, 5, mbq_pkg::SEL_A1, 32'hffc00000));
        send_beat(load_beat(1, 5, mbq_pkg::SEL_B1, 32'h00200000));
        send_beat(load_beat(1, 5, mbq_pkg::SEL_B2, 32'hffe00000));
        send_beat(load_beat(1, 6, mbq_pkg::SEL_B0, 32'h0));
        send_beat(load_beat(1, 0, 5, 32'h0));
        send_beat(load_beat(1, 7, 7, 32'h0));
        send_beat(sample_beat(1, 24'h123456));
        send_beat(sample_beat(1, 24'hedcba9));
        drain();
        for (int phase = 0; phase < 5; phase++)
        begin
            apb_write(mbq_pkg::REG_WET_MIX, mixes[phase]);
            apb_write(mbq_pkg::REG_OUT_LEVEL, levels[phase]);
            calm = (phase == 4);
            if (phase == 1) hold_off = 1;
            for (int i = 0; i < 380; i++)
            begin
                b = random_beat();
                if (b.action == mbq_pkg::ACT_LOAD && b.voice < 16 && b.section < 6
                    && b.coef_select < mbq_pkg::NCOEF && $urandom_range(0, 3) != 0)
                    b.coef_value = stable_coef(b.coef_select);
                send_beat(b);
                if (i == 200) drain();
            end
            drain();
        end
        if (errors == 0)
            $display("tb_multivoice_biquad_cascade: done, clean");
        else
            $display("tb_multivoice_biquad_cascade: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_multivoice_biquad_cascade: done, errors");
        $finish;
    end
endmodule
